>>> hdl/assert_macros.svh
// assertion macros used by the port-level checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every clock edge outside reset
`define PSRL_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check on every clock edge, reset included
`define PSRL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/psrl_pkg.sv
// shared types and constants of the per-source rate limiter
// no dependencies
package psrl_pkg;

   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [CSR_IDX_BITS-1:0] CSR_RATE         = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WINDOW       = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RELOAD       = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_STEP         = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_INIT_TIMEOUT = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_TRACKED  = 3'd5;

   localparam logic [15:0] RATE_RESET     = 16'd10;
   localparam logic [31:0] WINDOW_RESET   = 32'd60000;
   localparam logic [15:0] RELOAD_RESET   = 16'd10;
   localparam logic [31:0] STEP_RESET     = 32'd60000;
   localparam logic [31:0] TIMEOUT_RESET  = 32'd60000;
   localparam logic [6:0]  MAX_TRK_RESET  = 7'd64;

   typedef enum logic [1:0] {
      OP_CLEAR,
      OP_MISS,
      OP_HIT
   } op_type;

   typedef struct packed {
      logic   load;
      logic   rd_en;
      logic   step;
      logic   exec;
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic hit;
      logic last;
      logic empty;
   } sts_type;

endpackage

>>> hdl/psrl_req_if.sv
// request and response channel interfaces
// depends on nothing
interface psrl_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [63:0] addr_hi;
   logic [63:0] addr_lo;
   logic [31:0] now;
   modport source (output valid, action, addr_hi, addr_lo, now, input ready);
   modport sink (input valid, action, addr_hi, addr_lo, now, output ready);
endinterface

interface psrl_rsp_if;
   logic        valid;
   logic        ready;
   logic        permitted;
   logic [31:0] permit_total;
   logic [31:0] block_total;
   modport source (output valid, permitted, permit_total, block_total, input ready);
   modport sink (input valid, permitted, permit_total, block_total, output ready);
endinterface

>>> hdl/psrl_ctrl.sv
// controller: sequences request load, table scan and entry update
// depends on psrl_pkg
module psrl_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_action,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  psrl_pkg::sts_type sts,
   output psrl_pkg::cmd_type cmd
);
   import psrl_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOK,
      ST_CMP,
      ST_EXEC
   } state_type;

   state_type state_ff;
   op_type    op_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd    = '0;
      cmd.op = op_ff;
      unique case (state_ff)
         ST_IDLE: cmd.load  = req_valid;
         ST_LOOK: cmd.rd_en = 1'b1;
         ST_CMP:  cmd.step  = !sts.hit && !sts.last;
         ST_EXEC: cmd.exec  = out_free;
         default: cmd       = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         if ((state_ff == ST_EXEC) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  if (req_action) begin
                     op_ff    <= OP_CLEAR;
                     state_ff <= ST_EXEC;
                  end else if (sts.empty) begin
                     op_ff    <= OP_MISS;
                     state_ff <= ST_EXEC;
                  end else begin
                     state_ff <= ST_LOOK;
                  end
               end
            end
            ST_LOOK: state_ff <= ST_CMP;
            ST_CMP: begin
               priority if (sts.hit) begin
                  op_ff    <= OP_HIT;
                  state_ff <= ST_EXEC;
               end else if (sts.last) begin
                  op_ff    <= OP_MISS;
                  state_ff <= ST_EXEC;
               end else begin
                  state_ff <= ST_LOOK;
               end
            end
            ST_EXEC: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

>>> hdl/psrl_dp.sv
// datapath: settings, address table memory, credit and timeout update, totals
// depends on psrl_pkg
module psrl_dp #(
   parameter int TABLE_DEPTH = 64,
   parameter int TIME_BITS   = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [psrl_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [psrl_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic [63:0]                         req_addr_hi,
   input  logic [63:0]                         req_addr_lo,
   input  logic [31:0]                         req_now,
   input  psrl_pkg::cmd_type                   cmd,
   output psrl_pkg::sts_type                   sts,
   output logic                                rsp_permitted,
   output logic [31:0]                         rsp_permit_total,
   output logic [31:0]                         rsp_block_total
);
   import psrl_pkg::*;

   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int LW = (CW > 7) ? CW : 7;
   localparam int TW = TIME_BITS;
   localparam int WW = (TW > 32) ? TW : 32;

   // settings
   logic [15:0] rate_ff, reload_ff;
   logic [31:0] window_ff, step_ff;
   logic [6:0]  max_ff;

   // request word
   logic [63:0]   key_hi_ff, key_lo_ff;
   logic [TW-1:0] now_ff;
   logic [63:0]   now_ext;

   // table memory
   logic [63:0]   mem_hi    [TABLE_DEPTH];
   logic [63:0]   mem_lo    [TABLE_DEPTH];
   logic [15:0]   mem_cred  [TABLE_DEPTH];
   logic [TW-1:0] mem_first [TABLE_DEPTH];
   logic [TW-1:0] mem_last  [TABLE_DEPTH];
   logic          mem_blk   [TABLE_DEPTH];

   logic [63:0]   rd_hi_ff, rd_lo_ff;
   logic [15:0]   rd_cred_ff;
   logic [TW-1:0] rd_first_ff, rd_last_ff;
   logic          rd_blk_ff;

   logic [IW-1:0] idx_ff;
   logic [CW-1:0] used_ff, used_in, idx_next;
   logic [TW-1:0] timeout_ff, timeout_in;
   logic [31:0]   permits_ff, blocks_ff;
   logic          perm_out_ff;
   logic [31:0]   ptot_out_ff, btot_out_ff;

   // entry update
   logic [LW-1:0] max_w, lim;
   logic          full;
   logic [IW-1:0] slot, wr_addr;
   logic          we;
   logic [15:0]   fresh_cred, cred_dec;
   logic          ran_out;
   logic [63:0]   step_ext;
   logic [TW:0]   tmo_sum;
   logic [TW-1:0] tmo_grown, tmo_eff, since_last, elapsed;
   logic [WW-1:0] elapsed_w, window_w;
   logic          ok_in;
   logic [15:0]   wr_cred_in;
   logic [TW-1:0] wr_first_in, wr_last_in;
   logic          wr_blk_in;

   assign now_ext  = {32'd0, req_now};
   assign idx_next = CW'(idx_ff) + CW'(1);

   assign sts.hit   = (rd_hi_ff == key_hi_ff) && (rd_lo_ff == key_lo_ff);
   assign sts.last  = (idx_next >= used_ff);
   assign sts.empty = (used_ff == '0);

   // effective table limit, clamped to 1..depth
   assign max_w = LW'(max_ff);
   always_comb begin
      priority if (max_ff == 7'd0) begin
         lim = LW'(1);
      end else if (max_w > LW'(TABLE_DEPTH)) begin
         lim = LW'(TABLE_DEPTH);
      end else begin
         lim = max_w;
      end
   end
   assign full = (LW'(used_ff) >= lim);
   assign slot = full ? '0 : used_ff[IW-1:0];

   assign fresh_cred = rate_ff - 16'd1;
   assign cred_dec   = rd_cred_ff - 16'd1;
   assign ran_out    = (cred_dec == 16'd0);

   // shared timeout grows with saturation
   assign step_ext  = {32'd0, step_ff};
   assign tmo_sum   = {1'b0, timeout_ff} + {1'b0, step_ext[TW-1:0]};
   assign tmo_grown = tmo_sum[TW] ? '1 : tmo_sum[TW-1:0];
   assign tmo_eff   = ran_out ? tmo_grown : timeout_ff;

   assign since_last = now_ff - rd_last_ff;
   assign elapsed    = (now_ff >= rd_first_ff) ? (now_ff - rd_first_ff) : '0;
   assign elapsed_w  = WW'(elapsed);
   assign window_w   = WW'(window_ff);

   always_comb begin
      ok_in       = 1'b1;
      wr_cred_in  = fresh_cred;
      wr_first_in = now_ff;
      wr_last_in  = now_ff;
      wr_blk_in   = 1'b0;
      timeout_in  = timeout_ff;
      used_in     = used_ff;
      wr_addr     = idx_ff;
      unique case (cmd.op)
         OP_CLEAR: begin
            ok_in   = 1'b0;
            used_in = '0;
         end
         OP_MISS: begin
            wr_addr = slot;
            used_in = CW'(slot) + CW'(1);
         end
         OP_HIT: begin
            if (rd_blk_ff) begin
               timeout_in = tmo_eff;
               if ((now_ff <= rd_last_ff) || (since_last <= tmo_eff)) begin
                  ok_in       = 1'b0;
                  wr_cred_in  = ran_out ? reload_ff : cred_dec;
                  wr_first_in = rd_first_ff;
                  wr_last_in  = rd_last_ff;
                  wr_blk_in   = 1'b1;
               end
            end else if (elapsed_w <= window_w) begin
               wr_first_in = rd_first_ff;
               if (ran_out) begin
                  ok_in      = 1'b0;
                  wr_cred_in = reload_ff;
                  wr_blk_in  = 1'b1;
               end else begin
                  wr_cred_in = cred_dec;
               end
            end
         end
         default: ok_in = 1'b0;
      endcase
   end

   assign we = cmd.exec && (cmd.op != OP_CLEAR);

   always_ff @(posedge clock) begin
      if (we) begin
         mem_hi[wr_addr]    <= key_hi_ff;
         mem_lo[wr_addr]    <= key_lo_ff;
         mem_cred[wr_addr]  <= wr_cred_in;
         mem_first[wr_addr] <= wr_first_in;
         mem_last[wr_addr]  <= wr_last_in;
         mem_blk[wr_addr]   <= wr_blk_in;
      end
      if (cmd.rd_en) begin
         rd_hi_ff    <= mem_hi[idx_ff];
         rd_lo_ff    <= mem_lo[idx_ff];
         rd_cred_ff  <= mem_cred[idx_ff];
         rd_first_ff <= mem_first[idx_ff];
         rd_last_ff  <= mem_last[idx_ff];
         rd_blk_ff   <= mem_blk[idx_ff];
      end
   end

   // request word and result word, no reset needed
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_hi_ff <= req_addr_hi;
         key_lo_ff <= req_addr_lo;
         now_ff    <= now_ext[TW-1:0];
      end
      if (cmd.exec) begin
         perm_out_ff <= ok_in;
         if (cmd.op == OP_CLEAR) begin
            ptot_out_ff <= '0;
            btot_out_ff <= '0;
         end else if (ok_in) begin
            ptot_out_ff <= (permits_ff == '1) ? permits_ff : permits_ff + 32'd1;
            btot_out_ff <= blocks_ff;
         end else begin
            ptot_out_ff <= permits_ff;
            btot_out_ff <= (blocks_ff == '1) ? blocks_ff : blocks_ff + 32'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff    <= RATE_RESET;
         window_ff  <= WINDOW_RESET;
         reload_ff  <= RELOAD_RESET;
         step_ff    <= STEP_RESET;
         max_ff     <= MAX_TRK_RESET;
         idx_ff     <= '0;
         used_ff    <= '0;
         timeout_ff <= TW'({32'd0, TIMEOUT_RESET});
         permits_ff <= '0;
         blocks_ff  <= '0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_RATE:        rate_ff   <= csr_wdata[15:0];
               CSR_WINDOW:      window_ff <= csr_wdata;
               CSR_RELOAD:      reload_ff <= csr_wdata[15:0];
               CSR_STEP:        step_ff   <= csr_wdata;
               CSR_MAX_TRACKED: max_ff    <= csr_wdata[6:0];
               default:         ;
            endcase
         end
         if (cmd.load) begin
            idx_ff <= '0;
         end else if (cmd.step) begin
            idx_ff <= idx_next[IW-1:0];
         end
         if (cmd.exec) begin
            used_ff    <= used_in;
            timeout_ff <= timeout_in;
            if (cmd.op == OP_CLEAR) begin
               permits_ff <= '0;
               blocks_ff  <= '0;
            end else if (ok_in) begin
               if (permits_ff != '1) permits_ff <= permits_ff + 32'd1;
            end else begin
               if (blocks_ff != '1) blocks_ff <= blocks_ff + 32'd1;
            end
         end
      end
   end

   assign rsp_permitted    = perm_out_ff;
   assign rsp_permit_total = ptot_out_ff;
   assign rsp_block_total  = btot_out_ff;

endmodule

>>> hdl/per_source_rate_limiter.sv
// channel    dir  handshake    payload
// req_chan   in   valid/ready  action, addr_hi, addr_lo, now
// rsp_chan   out  valid/ready  permitted, permit_total, block_total
// csr        in   csr_wr_en    csr_index, csr_wdata
//
// clear action or empty table: the request goes from idle straight to execute.
// otherwise the table is scanned one entry at a time through the single
// memory read port, a look state and a compare state per entry, up to a hit
// or the last entry in use. one word at a time; the next request is
// taken once the result sits in the output register.
// reset is synchronous and needs no clearing pass; a stalled result holds.
// top level: controller, datapath; depends on psrl_pkg and the channel interfaces
module per_source_rate_limiter #(
   parameter int TABLE_DEPTH = 64,
   parameter int TIME_BITS   = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   psrl_req_if.sink                           req_chan,
   psrl_rsp_if.source                         rsp_chan,
   input  logic                               csr_wr_en,
   input  logic [psrl_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [psrl_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import psrl_pkg::*;

   cmd_type cmd;
   sts_type sts;

   psrl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_action (req_chan.action),
      .req_ready  (req_chan.ready),
      .rsp_valid  (rsp_chan.valid),
      .rsp_ready  (rsp_chan.ready),
      .sts        (sts),
      .cmd        (cmd)
   );

   psrl_dp #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .TIME_BITS   (TIME_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_addr_hi      (req_chan.addr_hi),
      .req_addr_lo      (req_chan.addr_lo),
      .req_now          (req_chan.now),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_permitted    (rsp_chan.permitted),
      .rsp_permit_total (rsp_chan.permit_total),
      .rsp_block_total  (rsp_chan.block_total)
   );

endmodule

>>> hdl/psrl_checker.sv
// port-level checks of the rate limiter, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module psrl_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_permitted,
   input logic [31:0] rsp_permit_total,
   input logic [31:0] rsp_block_total
);

   `PSRL_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "result word dropped while stalled")
   `PSRL_ASSERT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable({rsp_permitted, rsp_permit_total, rsp_block_total}), "result word changed while stalled")
   `PSRL_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid, "result word right after reset")
   `PSRL_ASSERT(a_permit_counted, clock, reset, rsp_valid && rsp_permitted |-> rsp_permit_total != 32'd0, "permit not counted in total")

endmodule

bind per_source_rate_limiter psrl_checker u_psrl_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_permitted    (rsp_chan.permitted),
   .rsp_permit_total (rsp_chan.permit_total),
   .rsp_block_total  (rsp_chan.block_total)
);
